/* design/psieve_pkg.sv */
// shared types and constants for the prime sieve block
// no dependencies; imported by the sieve engine and the top level
`default_nettype none

package psieve_pkg;

  localparam int FIELD_W = 16;

  typedef struct packed {
    logic [FIELD_W-1:0] prime_count;
    logic [FIELD_W-1:0] largest_prime;
  } res_t;

  typedef struct packed {
    logic idle;
    logic done;
    res_t res;
  } eng_stat_t;

endpackage

`default_nettype wire

/* design/psieve_ram.sv */
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`default_nettype none

module psieve_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/psieve_engine.sv */
// sieve sequencer: clears, tests, marks and scans the composite bit store
// depends on psieve_pkg and psieve_ram
`default_nettype none

module psieve_engine
  import psieve_pkg::*;
#(
  parameter int MAX_LIMIT = 65535
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [FIELD_W-1:0] limit_n,
  input  wire logic               take,
  output eng_stat_t               stat
);

  localparam int AW = $clog2(MAX_LIMIT + 1);
  localparam int CW = (AW > FIELD_W) ? AW : FIELD_W;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_CLEAR     = 3'd1;
  localparam logic [2:0] S_TEST      = 3'd2;
  localparam logic [2:0] S_TEST_WAIT = 3'd3;
  localparam logic [2:0] S_MARK      = 3'd4;
  localparam logic [2:0] S_SCAN      = 3'd5;
  localparam logic [2:0] S_SCAN_LAST = 3'd6;
  localparam logic [2:0] S_DONE      = 3'd7;

  logic [2:0]    state;
  logic [AW-1:0] n;
  logic [AW-1:0] i;
  logic [AW:0]   sq;
  logic [AW:0]   k;
  logic [AW-1:0] cnt;
  logic [AW-1:0] pidx;
  logic          pend;
  logic [AW-1:0] count;
  logic [AW-1:0] largest;

  logic [CW-1:0] lim_ext;
  logic [AW-1:0] n_sat;
  logic [AW:0]   n_ext;
  logic [AW:0]   sq_next;
  logic [AW:0]   k_next;

  logic          we;
  logic [AW-1:0] waddr;
  logic          wdata;
  logic [AW-1:0] raddr;
  logic          rdata;

  assign lim_ext = CW'(limit_n);
  assign n_sat   = (lim_ext > CW'(MAX_LIMIT)) ? AW'(MAX_LIMIT) : AW'(lim_ext);
  assign n_ext   = (AW+1)'(n);
  // (i+1)^2 = i^2 + 2i + 1
  assign sq_next = sq + {i, 1'b1};
  assign k_next  = k + (AW+1)'(i);

  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = 1'b0;
    unique case (state)
      S_CLEAR: begin
        we = 1'b1;
      end
      S_MARK: begin
        we    = 1'b1;
        waddr = k[AW-1:0];
        wdata = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign raddr = (state == S_SCAN) ? cnt : i;

  psieve_ram #(
    .WIDTH(1),
    .DEPTH(MAX_LIMIT + 1)
  ) u_marks (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pend    <= 1'b0;
      count   <= '0;
      largest <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            n       <= n_sat;
            count   <= '0;
            largest <= '0;
            cnt     <= AW'(2);
            if (n_sat < AW'(2)) begin
              state <= S_DONE;
            end else begin
              state <= S_CLEAR;
            end
          end
        end
        S_CLEAR: begin
          if (cnt == n) begin
            i     <= AW'(2);
            sq    <= (AW+1)'(4);
            state <= S_TEST;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        S_TEST: begin
          if (sq > n_ext) begin
            cnt   <= AW'(2);
            pend  <= 1'b0;
            state <= S_SCAN;
          end else begin
            state <= S_TEST_WAIT;
          end
        end
        S_TEST_WAIT: begin
          if (!rdata) begin
            k     <= sq;
            state <= S_MARK;
          end else begin
            i     <= i + AW'(1);
            sq    <= sq_next;
            state <= S_TEST;
          end
        end
        S_MARK: begin
          k <= k_next;
          if (k_next > n_ext) begin
            i     <= i + AW'(1);
            sq    <= sq_next;
            state <= S_TEST;
          end
        end
        S_SCAN: begin
          pend <= 1'b1;
          pidx <= cnt;
          if (pend && !rdata) begin
            count   <= count + AW'(1);
            largest <= pidx;
          end
          if (cnt == n) begin
            state <= S_SCAN_LAST;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        S_SCAN_LAST: begin
          pend <= 1'b0;
          if (!rdata) begin
            count   <= count + AW'(1);
            largest <= pidx;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign stat.idle                  = (state == S_IDLE);
  assign stat.done                  = (state == S_DONE);
  assign stat.res.prime_count       = FIELD_W'(count);
  assign stat.res.largest_prime     = FIELD_W'(largest);

  // marking never runs past the limit
  a_mark_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK) |-> (k <= n_ext))
    else $error("mark write beyond limit");

  // clear and scan addresses stay inside 2..n
  a_cnt_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR || state == S_SCAN) |-> (cnt >= AW'(2) && cnt <= n))
    else $error("sweep address out of range");

  // the number of primes found never exceeds the largest one found
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= largest)
    else $error("prime count exceeds largest prime");

  // a finished result stays until it is taken
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !take) |=> (state == S_DONE && $stable(count)))
    else $error("result dropped before handoff");

endmodule

`default_nettype wire

/* design/prime_sieve_count_and_max_top.sv */
// Prime sieve: each item carries a limit n (saturated to MAX_LIMIT); the block
// returns the number of primes in 2..n and the largest of them, both 0 for n < 2.
// One item is worked at a time on a 1-bit-wide single-port-write memory of
// MAX_LIMIT+1 entries. For each item the engine clears entries 2..n, tests
// each candidate i with i*i <= n and, for each prime i, marks its multiples
// from i*i up to n as composite, then scans 2..n to count the primes and
// find the largest. The result sits in an output register, so a new item may
// be accepted while it waits.
// depends on psieve_pkg and psieve_engine
`default_nettype none

module prime_sieve_count_and_max_top
  import psieve_pkg::*;
#(
  parameter int MAX_LIMIT = 65535
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [FIELD_W-1:0] limit_n,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [FIELD_W-1:0] prime_count,
  output logic      [FIELD_W-1:0] largest_prime
);

  eng_stat_t stat;
  logic      start;
  logic      take;

  assign in_stall = !stat.idle;
  assign start    = in_valid && !in_stall;
  // hand the result over once the output register is free or draining
  assign take     = stat.done && (!out_valid || !out_stall);

  psieve_engine #(
    .MAX_LIMIT(MAX_LIMIT)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .limit_n(limit_n),
    .take   (take),
    .stat   (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      prime_count   <= stat.res.prime_count;
      largest_prime <= stat.res.largest_prime;
    end
  end

  // an item is only taken while the engine is idle, and it leaves idle next
  a_start_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    start |=> !stat.idle)
    else $error("engine stayed idle after an accepted item");

  // engine idle and done are exclusive
  a_idle_done_excl: assert property (@(posedge clk) disable iff (rst)
    !(stat.idle && stat.done))
    else $error("engine idle and done at once");

  // a handoff always leaves a valid result in the output register
  a_take_fills_out: assert property (@(posedge clk) disable iff (rst)
    take |=> (out_valid && stat.idle))
    else $error("handoff did not fill the output register");

endmodule

`default_nettype wire
